>>> rtl/core/fisr_pkg.sv
package fisr_pkg;

    // Single-precision constants used by the datapath.
    localparam logic [31:0] MAGIC_GUESS     = 32'h5f3759df;
    localparam logic [31:0] CANON_NAN       = 32'h7FC00000;
    localparam logic [31:0] FP_HALF         = 32'h3F000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3FC00000;

    // Pipeline depths of the arithmetic units.
    localparam int MUL_LAT  = 3;
    localparam int ADD_LAT  = 4;
    localparam int STEP_LAT = 3 * MUL_LAT + ADD_LAT;

    localparam int DEFAULT_NEWTON_STEPS = 2;

    // Operand class that bypasses the normal rounding path.
    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_INF,
        SPEC_NAN
    } spec_kind_t;

    // Position of the most significant set bit, zero for an all-zero word.
    function automatic logic [5:0] lead_one48(input logic [47:0] v);
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

    // Shift a magnitude by rs (right when positive), round to nearest even
    // and pack it with biased exponent expn. Overflow gives infinity.
    function automatic logic [31:0] round_pack(
        input logic               sign,
        input logic [47:0]        mag,
        input logic signed [10:0] rs,
        input logic signed [10:0] expn
    );
        logic [111:0] wide;
        logic [23:0]  m;
        logic         rnd;
        logic         stk;
        logic [24:0]  mr;
        logic [33:0]  val;
        logic [5:0]   ls;
        logic [6:0]   rsc;
        logic [31:0]  res;
        wide = '0;
        rsc  = '0;
        ls   = '0;
        if (rs <= 11'sd0)
        begin
            ls  = 6'(-rs);
            m   = 24'(mag << ls);
            rnd = 1'b0;
            stk = 1'b0;
        end
        else
        begin
            rsc  = (rs > 11'sd64) ? 7'd64 : 7'(rs);
            wide = {mag, 64'b0} >> rsc;
            m    = wide[87:64];
            rnd  = wide[63];
            stk  = |wide[62:0];
        end
        mr  = {1'b0, m} + 25'(rnd & (stk | m[0]));
        val = ({25'b0, 9'(expn - 11'sd1)} << 23) + 34'(mr);
        if (mag == '0)
        begin
            res = {sign, 31'b0};
        end
        else if (val >= 34'h07F800000)
        begin
            res = {sign, 8'hFF, 23'b0};
        end
        else
        begin
            res = {sign, val[30:0]};
        end
        return res;
    endfunction

endpackage

>>> rtl/core/fisr_delay.sv
module fisr_delay
    import fisr_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = MUL_LAT
)
(
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] data_reg [DEPTH];

    // Plain shift line that keeps side operands aligned with the units.
    always_ff @(posedge clk)
    begin
        data_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            data_reg[i] <= data_reg[i-1];
        end
    end

    assign dout = data_reg[DEPTH-1];

endmodule

>>> rtl/core/fisr_fmul.sv
module fisr_fmul
    import fisr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        out_valid,
    output logic [31:0] result
);

    logic [7:0]  ea;
    logic [7:0]  eb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    spec_kind_t  spec_s0;

    logic               v1_reg, v2_reg, v3_reg;
    logic               sign1_reg, sign2_reg;
    logic [47:0]        prod1_reg, prod2_reg;
    logic [8:0]         esum1_reg;
    spec_kind_t         spec1_reg, spec2_reg;
    logic signed [10:0] rs2_reg, expn2_reg;
    logic [31:0]        res3_reg;

    logic signed [10:0] lead_s, esum_s, rs_a, rs_b, rs_next, expn_next;
    logic [31:0]        res_next;

    // Operand classification.
    always_comb
    begin
        ea     = a[30:23];
        eb     = b[30:23];
        nan_a  = (ea == 8'hFF) && (a[22:0] != '0);
        nan_b  = (eb == 8'hFF) && (b[22:0] != '0);
        inf_a  = (ea == 8'hFF) && (a[22:0] == '0);
        inf_b  = (eb == 8'hFF) && (b[22:0] == '0);
        zero_a = (ea == 8'h00) && (a[22:0] == '0);
        zero_b = (eb == 8'h00) && (b[22:0] == '0);
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
        begin
            spec_s0 = SPEC_NAN;
        end
        else if (inf_a || inf_b)
        begin
            spec_s0 = SPEC_INF;
        end
        else if (zero_a || zero_b)
        begin
            spec_s0 = SPEC_ZERO;
        end
        else
        begin
            spec_s0 = SPEC_NONE;
        end
    end

    // Normalization shift and exponent from the product's leading one.
    always_comb
    begin
        lead_s    = signed'({5'b0, lead_one48(prod1_reg)});
        esum_s    = signed'({2'b0, esum1_reg});
        rs_a      = lead_s - 11'sd23;
        rs_b      = 11'sd151 - esum_s;
        rs_next   = (rs_a > rs_b) ? rs_a : rs_b;
        expn_next = rs_next + esum_s - 11'sd150;
    end

    // Final rounding or special value.
    always_comb
    begin
        case (spec2_reg)
            SPEC_NONE: res_next = round_pack(sign2_reg, prod2_reg, rs2_reg, expn2_reg);
            SPEC_ZERO: res_next = {sign2_reg, 31'b0};
            SPEC_INF:  res_next = {sign2_reg, 8'hFF, 23'b0};
            default:   res_next = CANON_NAN;
        endcase
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Datapath registers: multiply, normalize setup, round.
    always_ff @(posedge clk)
    begin
        sign1_reg <= a[31] ^ b[31];
        prod1_reg <= {(ea != 8'h00), a[22:0]} * {(eb != 8'h00), b[22:0]};
        esum1_reg <= 9'((ea == 8'h00) ? 8'd1 : ea) + 9'((eb == 8'h00) ? 8'd1 : eb);
        spec1_reg <= spec_s0;

        sign2_reg <= sign1_reg;
        prod2_reg <= prod1_reg;
        rs2_reg   <= rs_next;
        expn2_reg <= expn_next;
        spec2_reg <= spec1_reg;

        res3_reg  <= res_next;
    end

    assign out_valid = v3_reg;
    assign result    = res3_reg;

endmodule

>>> rtl/core/fisr_fadd.sv
module fisr_fadd
    import fisr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        out_valid,
    output logic [31:0] result
);

    logic [7:0]  ea, eb, ea_e, eb_e;
    logic        nan_a, nan_b, inf_a, inf_b, a_big;
    spec_kind_t  spec_s0;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               sign1_reg, sign2_reg, sign3_reg;
    logic               sub1_reg, sub2_reg;
    logic               isign1_reg, isign2_reg, isign3_reg;
    logic [7:0]         ebig1_reg, ebig2_reg;
    logic [23:0]        mbig1_reg, msmall1_reg;
    logic [7:0]         diff1_reg;
    spec_kind_t         spec1_reg, spec2_reg, spec3_reg;
    logic [27:0]        sum2_reg;
    logic [47:0]        mag3_reg;
    logic signed [10:0] rs3_reg, expn3_reg;
    logic [31:0]        res4_reg;

    logic [4:0]         dc;
    logic [53:0]        wide;
    logic [26:0]        aligned;
    logic [27:0]        sum_next;
    logic signed [10:0] lead_s, e_s, rs_a, rs_b, rs_next, expn_next;
    logic               sign_next;
    logic [31:0]        res_next;

    // Classification and ordering of the operands by magnitude.
    always_comb
    begin
        ea    = a[30:23];
        eb    = b[30:23];
        ea_e  = (ea == 8'h00) ? 8'd1 : ea;
        eb_e  = (eb == 8'h00) ? 8'd1 : eb;
        nan_a = (ea == 8'hFF) && (a[22:0] != '0);
        nan_b = (eb == 8'hFF) && (b[22:0] != '0);
        inf_a = (ea == 8'hFF) && (a[22:0] == '0);
        inf_b = (eb == 8'hFF) && (b[22:0] == '0);
        a_big = (a[30:0] >= b[30:0]);
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31])))
        begin
            spec_s0 = SPEC_NAN;
        end
        else if (inf_a || inf_b)
        begin
            spec_s0 = SPEC_INF;
        end
        else
        begin
            spec_s0 = SPEC_NONE;
        end
    end

    // Alignment of the smaller operand with guard, round and sticky bits.
    always_comb
    begin
        dc         = (diff1_reg > 8'd31) ? 5'd31 : diff1_reg[4:0];
        wide       = {msmall1_reg, 30'b0} >> dc;
        aligned    = {wide[53:28], |wide[27:0]};
        if (sub1_reg)
        begin
            sum_next = {1'b0, mbig1_reg, 3'b0} - {1'b0, aligned};
        end
        else
        begin
            sum_next = {1'b0, mbig1_reg, 3'b0} + {1'b0, aligned};
        end
    end

    // Normalization shift; an exact zero from cancellation is positive.
    always_comb
    begin
        lead_s    = signed'({5'b0, lead_one48({20'b0, sum2_reg})});
        e_s       = signed'({3'b0, ebig2_reg});
        rs_a      = lead_s - 11'sd23;
        rs_b      = 11'sd4 - e_s;
        rs_next   = (rs_a > rs_b) ? rs_a : rs_b;
        expn_next = rs_next + e_s - 11'sd3;
        sign_next = (sum2_reg == '0 && sub2_reg) ? 1'b0 : sign2_reg;
    end

    // Final rounding or special value.
    always_comb
    begin
        case (spec3_reg)
            SPEC_NONE: res_next = round_pack(sign3_reg, mag3_reg, rs3_reg, expn3_reg);
            SPEC_ZERO: res_next = {sign3_reg, 31'b0};
            SPEC_INF:  res_next = {isign3_reg, 8'hFF, 23'b0};
            default:   res_next = CANON_NAN;
        endcase
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Datapath registers: order, align and add, normalize setup, round.
    always_ff @(posedge clk)
    begin
        sign1_reg   <= a_big ? a[31] : b[31];
        sub1_reg    <= a[31] ^ b[31];
        isign1_reg  <= inf_a ? a[31] : b[31];
        ebig1_reg   <= a_big ? ea_e : eb_e;
        mbig1_reg   <= a_big ? {(ea != 8'h00), a[22:0]} : {(eb != 8'h00), b[22:0]};
        msmall1_reg <= a_big ? {(eb != 8'h00), b[22:0]} : {(ea != 8'h00), a[22:0]};
        diff1_reg   <= a_big ? (ea_e - eb_e) : (eb_e - ea_e);
        spec1_reg   <= spec_s0;

        sign2_reg  <= sign1_reg;
        sub2_reg   <= sub1_reg;
        isign2_reg <= isign1_reg;
        ebig2_reg  <= ebig1_reg;
        sum2_reg   <= sum_next;
        spec2_reg  <= spec1_reg;

        sign3_reg  <= sign_next;
        isign3_reg <= isign2_reg;
        mag3_reg   <= {20'b0, sum2_reg};
        rs3_reg    <= rs_next;
        expn3_reg  <= expn_next;
        spec3_reg  <= spec2_reg;

        res4_reg   <= res_next;
    end

    assign out_valid = v4_reg;
    assign result    = res4_reg;

endmodule

>>> rtl/core/fisr_newton.sv
module fisr_newton
    import fisr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] half,
    input  logic [31:0] y,
    output logic        out_valid,
    output logic [31:0] half_out,
    output logic [31:0] y_out
);

    logic        v1, v2, v3;
    logic [31:0] t1, t2, t3;
    logic [31:0] y3, y6, y10;

    // t1 = half * y
    fisr_fmul u_mul_hy (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .a         (half),
        .b         (y),
        .out_valid (v1),
        .result    (t1)
    );

    fisr_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_y3 (
        .clk  (clk),
        .din  (y),
        .dout (y3)
    );

    // t2 = t1 * y
    fisr_fmul u_mul_ty (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .a         (t1),
        .b         (y3),
        .out_valid (v2),
        .result    (t2)
    );

    fisr_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_y6 (
        .clk  (clk),
        .din  (y3),
        .dout (y6)
    );

    // t3 = 1.5 - t2
    fisr_fadd u_sub (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .a         (FP_THREE_HALVES),
        .b         ({~t2[31], t2[30:0]}),
        .out_valid (v3),
        .result    (t3)
    );

    fisr_delay #(.WIDTH(32), .DEPTH(ADD_LAT)) u_dly_y10 (
        .clk  (clk),
        .din  (y6),
        .dout (y10)
    );

    // Refined estimate y * t3.
    fisr_fmul u_mul_yt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .a         (y10),
        .b         (t3),
        .out_valid (out_valid),
        .result    (y_out)
    );

    // The half operand follows the step for the next refinement.
    fisr_delay #(.WIDTH(32), .DEPTH(STEP_LAT)) u_dly_half (
        .clk  (clk),
        .din  (half),
        .dout (half_out)
    );

endmodule

>>> rtl/core/fast_inverse_square_root.sv
// Channel   Signals                   Direction  Meaning
// request   start, operand_bits       in         one single-precision operand
// status    busy                      out        always low, never holds requests
// result    done, recip_sqrt_bits     out        approximate 1/sqrt, one-cycle strobe
//
// One request is taken every clock cycle; each result passes through the
// half multiply, the refinement steps and an output register, in that order.
// Each refinement step is made up of the 3-stage multipliers and the 4-stage
// adder. Reset clears only the valid bits.
// The receiver cannot stall, so nothing is ever held or repeated.
module fast_inverse_square_root
    import fisr_pkg::*;
#(
    parameter int NEWTON_STEPS = DEFAULT_NEWTON_STEPS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] operand_bits,
    output logic        busy,
    output logic        done,
    output logic [31:0] recip_sqrt_bits
);

    localparam int LATENCY = MUL_LAT + NEWTON_STEPS * STEP_LAT + 1;

    logic        stage_valid [NEWTON_STEPS+1];
    logic [31:0] stage_half  [NEWTON_STEPS+1];
    logic [31:0] stage_y     [NEWTON_STEPS+1];
    logic [31:0] guess;
    logic        done_reg;
    logic [31:0] result_reg;
    logic [31:0] final_y;

    assign busy = 1'b0;

    // Initial guess from the integer view of the operand.
    assign guess = MAGIC_GUESS - {operand_bits[31], operand_bits[31:1]};

    fisr_fmul u_half (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .a         (operand_bits),
        .b         (FP_HALF),
        .out_valid (stage_valid[0]),
        .result    (stage_half[0])
    );

    fisr_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_guess (
        .clk  (clk),
        .din  (guess),
        .dout (stage_y[0])
    );

    // Chain of refinement steps.
    for (genvar gi = 0; gi < NEWTON_STEPS; gi++)
    begin : g_step
        fisr_newton u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[gi]),
            .half      (stage_half[gi]),
            .y         (stage_y[gi]),
            .out_valid (stage_valid[gi+1]),
            .half_out  (stage_half[gi+1]),
            .y_out     (stage_y[gi+1])
        );
    end

    // Any NaN leaves as the canonical quiet NaN.
    always_comb
    begin
        final_y = stage_y[NEWTON_STEPS];
        if (final_y[30:23] == 8'hFF && final_y[22:0] != '0)
        begin
            final_y = CANON_NAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_valid[NEWTON_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= final_y;
    end

    assign done            = done_reg;
    assign recip_sqrt_bits = result_reg;

    // Every result traces back to an earlier request.
    a_done_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching request");

    // Only the canonical NaN pattern may leave the block.
    a_canon_nan : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(recip_sqrt_bits[30:23] == 8'hFF && recip_sqrt_bits[22:0] != 23'd0
                   && recip_sqrt_bits != CANON_NAN))
        else $error("non-canonical NaN on result");

    // A request with the valid path active must produce a strobe later.
    a_request_done : assert property (@(posedge clk) disable iff (!rst_n)
        $past(start, LATENCY) && $past(rst_n, LATENCY) && $past(rst_n, 1) |-> done)
        else $error("request lost in pipeline");

endmodule
